// ===== design/lfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpf_pkg
// shared widths, types and constants of the linearizer, fir and peak finder
// ----------------------------------------------------------------------------
package lfpf_pkg;

  localparam int CHANNELS  = 32;
  localparam int TAPS      = 5;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CHAN_W    = 5;
  localparam int ADC_W     = 14;
  localparam int COEFF_W   = 24;
  localparam int RAW_W     = 12;
  localparam int MULT_W    = 8;
  localparam int SHIFT_W   = 4;
  localparam int SAMP_W    = 18;
  localparam int PROD_W    = RAW_W + MULT_W;
  localparam int FIR_SHIFT = 6;
  localparam int WEIGHT_W  = 7;
  localparam int TAP_PROD_W = SAMP_W + 1 + WEIGHT_W;
  localparam int TERM_W    = 20;
  localparam int ACC_W     = TERM_W + 3;

  localparam logic [SAMP_W-1:0] OUT_MAX = 18'h3FFFF;

  localparam logic signed [WEIGHT_W-1:0] FIR_WEIGHT [TAPS] = '{
    7'sd24, 7'sd31, 7'sd16, -7'sd35, -7'sd36
  };

  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    logic [RAW_W-1:0]   base;
  } coeff_t;

  // per-channel word: sample history newest at index 0, output history likewise
  typedef struct packed {
    logic [1:0][SAMP_W-1:0]      outp;
    logic [TAPS-2:0][SAMP_W-1:0] samp;
  } chan_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MAC,
    S_WB
  } fsm_state_t;

endpackage

// ===== design/lfpf_lin.sv =====
// ----------------------------------------------------------------------------
// lfpf_lin
// sample linearizer: baseline removal, scale by multiplier, right shift
// ----------------------------------------------------------------------------
module lfpf_lin
  import lfpf_pkg::*;
(
  input  logic [RAW_W-1:0]  raw,
  input  coeff_t            coeff,
  output logic [SAMP_W-1:0] lin
);

  logic [RAW_W:0]    diff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [SHIFT_W:0]  sh_amt;

  always_comb begin
    diff    = {1'b0, raw} - {1'b0, coeff.base};
    prod    = diff[RAW_W-1:0] * coeff.mult;
    sh_amt  = {1'b0, coeff.shift} + (SHIFT_W + 1)'(2);
    prod_sh = prod >> sh_amt;
    // below baseline or zero multiplier gives zero
    if ((coeff.mult == '0) || diff[RAW_W]) begin
      lin = '0;
    end else begin
      lin = prod_sh[SAMP_W-1:0];
    end
  end

endmodule

// ===== design/linearize_fir_peak_finder_top.sv =====
// ----------------------------------------------------------------------------
// linearize_fir_peak_finder_top
// per-channel adc linearizer, 5-tap fir and peak finder on a state memory
// ----------------------------------------------------------------------------
// usage
//   input beat: channel, raw adc sample and coefficient word (mult, shift,
//   baseline). output beat: channel echo, clamped fir output and a peak flag
//   that says the previous output of the channel beat both its neighbors.
//   each channel owns one word of the state memory holding its last four
//   linearized samples and last two outputs
// sequencing
//   one beat in flight: accept/read, linearize, tap products, sum/write-back.
//   a result lands in the output register at its write-back step, and the
//   next input beat can be taken on the cycle after that write-back, so a
//   beat is not taken before the last is through, as set by the
//   read-modify-write of the channel word (registered read, product, sum)
// reset
//   rst_n (synchronous, active low) clears the fsm, the output valid and the
//   per-channel valid bits; a channel never written reads as all-zero history
// stall
//   the output register holds a beat while out_stall is high; write-back of
//   the next beat waits there, and in_stall stays high until it is done
// ----------------------------------------------------------------------------
module linearize_fir_peak_finder_top
  import lfpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [ADC_W-1:0]   in_adc_sample,
  input  logic [COEFF_W-1:0] in_lin_coeff,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAN_W-1:0]  out_channel,
  output logic [SAMP_W-1:0]  out_filter_out,
  output logic               out_peak_flag
);

  // control
  fsm_state_t state_r, state_nxt;
  logic       in_acc;
  logic       wb_go;
  logic       out_valid_r;

  // captured beat
  logic [CHAN_W-1:0]   chan_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic                chan_ok_r;
  logic [RAW_W-1:0]    raw_r;
  coeff_t              coeff_r;

  // channel state memory and valid bits
  chan_state_t         mem [CHANNELS];
  chan_state_t         mem_rd_r;
  logic [CHANNELS-1:0] vld_r;
  logic                mem_we;
  chan_state_t         wr_data;
  logic [CH_IDX_W-1:0] in_idx;
  logic                in_chan_ok;

  // datapath
  logic [SAMP_W-1:0]             lin;
  logic [SAMP_W-1:0]             lin_r;
  chan_state_t                   cur_r;
  logic signed [TERM_W-1:0]      term_r [TAPS];
  logic signed [TERM_W-1:0]      term   [TAPS];
  logic [SAMP_W-1:0]             tap_x  [TAPS];
  logic signed [TAP_PROD_W-1:0]  tap_prod;
  logic signed [ACC_W-1:0]       acc;
  logic [SAMP_W-1:0]             result;
  logic                          peak;

  // output register
  logic [CHAN_W-1:0] out_chan_r;
  logic [SAMP_W-1:0] out_fir_r;
  logic              out_peak_r;

  assign in_acc     = in_valid && !in_stall;
  assign in_idx     = CH_IDX_W'(in_channel);
  assign in_chan_ok = ({22'd0, in_channel} < 27'(CHANNELS));

  // fsm: one beat walks read, linearize, products, write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    wb_go     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MAC;
      S_MAC: state_nxt = S_WB;
      S_WB: begin
        // output register must be free or draining this cycle
        if (!out_valid_r || !out_stall) begin
          wb_go     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r    <= in_channel;
      idx_r     <= in_idx;
      chan_ok_r <= in_chan_ok;
      raw_r     <= in_adc_sample[RAW_W-1:0];
      coeff_r   <= coeff_t'(in_lin_coeff);
    end
  end

  // state memory: read at accept, write at write-back; one beat in flight
  // means a read never overlaps a pending write of the same word
  assign mem_we = wb_go && chan_ok_r;

  always_comb begin
    wr_data.samp[0] = lin_r;
    for (int k = 1; k < TAPS - 1; k++) begin
      wr_data.samp[k] = cur_r.samp[k-1];
    end
    wr_data.outp[0] = result;
    wr_data.outp[1] = cur_r.outp[0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= wr_data;
    end
    if (in_acc) begin
      mem_rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // linearize and pick up history
  lfpf_lin u_lin (
    .raw   (raw_r),
    .coeff (coeff_r),
    .lin   (lin)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      lin_r <= lin;
      // unwritten or out-of-range channel sees an all-zero history
      if (chan_ok_r && vld_r[idx_r]) begin
        cur_r <= mem_rd_r;
      end else begin
        cur_r <= '0;
      end
    end
  end

  // tap products, each floored by the fir shift
  always_comb begin
    tap_x[0] = lin_r;
    for (int t = 1; t < TAPS; t++) begin
      tap_x[t] = cur_r.samp[t-1];
    end
    for (int t = 0; t < TAPS; t++) begin
      tap_prod = $signed({1'b0, tap_x[t]}) * FIR_WEIGHT[t];
      term[t]  = TERM_W'(tap_prod >>> FIR_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MAC) begin
      for (int t = 0; t < TAPS; t++) begin
        term_r[t] <= term[t];
      end
    end
  end

  // sum, clamp and peak check
  always_comb begin
    acc = '0;
    for (int t = 0; t < TAPS; t++) begin
      acc = acc + ACC_W'(term_r[t]);
    end
    priority if (acc < 0) begin
      result = '0;
    end else if (acc > $signed({5'd0, OUT_MAX})) begin
      result = OUT_MAX;
    end else begin
      result = acc[SAMP_W-1:0];
    end
    peak = (cur_r.outp[0] > result) && (cur_r.outp[0] > cur_r.outp[1]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_chan_r <= chan_r;
      out_fir_r  <= result;
      out_peak_r <= peak;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_chan_r;
  assign out_filter_out = out_fir_r;
  assign out_peak_flag  = out_peak_r;

`ifndef NO_ASSERTIONS
  // an accepted beat always starts the read step
  a_acc_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_RD)
    else $error("accepted beat did not enter read step");

  // write-back never overruns a held output beat
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    wb_go |-> (!out_valid_r || !out_stall))
    else $error("write-back while output held");

  // a finished write-back leaves a valid output and a valid channel word
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid_r && vld_r[$past(idx_r)] && state_r == S_IDLE)
    else $error("write-back did not complete");

  // memory is only written from the write-back step
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_WB)
    else $error("memory write outside write-back");
`endif

endmodule
